>>> rtl/core/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and bit functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] regs_type;

   // Message expansion taps read by the round unit.
   typedef struct packed {
      word_type w0;
      word_type w3;
      word_type w4;
      word_type w7;
      word_type w10;
      word_type w13;
   } taps_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_RUN,
      ST_FOLD,
      ST_OUT
   } state_type;

   localparam word_type T_LOW  = 32'h79cc4519;
   localparam word_type T_HIGH = 32'h7a879d8a;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   // Index 0 is the first word of the initial value.
   localparam regs_type SM3_IV = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sm3_if.sv
// ----------------------------------------------------------------------------
// SM3 channel interfaces
// Valid/ready channels for message bytes and for digest results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_valid;
   logic       msg_last;

   modport source (output valid, output msg_byte, output byte_valid, output msg_last,
                   input ready);
   modport sink (input valid, input msg_byte, input byte_valid, input msg_last,
                 output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_0;
   logic [31:0] digest_word_1;
   logic [31:0] digest_word_2;
   logic [31:0] digest_word_3;
   logic [31:0] digest_word_4;
   logic [31:0] digest_word_5;
   logic [31:0] digest_word_6;
   logic [31:0] digest_word_7;

   modport source (output valid, output digest_word_0, output digest_word_1,
                   output digest_word_2, output digest_word_3, output digest_word_4,
                   output digest_word_5, output digest_word_6, output digest_word_7,
                   input ready);
   modport sink (input valid, input digest_word_0, input digest_word_1,
                 input digest_word_2, input digest_word_3, input digest_word_4,
                 input digest_word_5, input digest_word_6, input digest_word_7,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/core/sm3_round.sv
// ----------------------------------------------------------------------------
// SM3 round unit
// One compression round and one message expansion step, reused for all rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_round (
   input  wire sm3_pkg::regs_type regs_now,
   input  wire sm3_pkg::taps_type taps,
   input  wire logic [5:0]        round_idx,
   output sm3_pkg::regs_type      regs_next,
   output sm3_pkg::word_type      w_new
);

   logic              early;
   sm3_pkg::word_type tj;
   sm3_pkg::word_type a12;
   sm3_pkg::word_type ss1;
   sm3_pkg::word_type ss2;
   sm3_pkg::word_type ff;
   sm3_pkg::word_type gg;
   sm3_pkg::word_type tt1;
   sm3_pkg::word_type tt2;

   assign early = (round_idx[5:4] == 2'b00);
   assign tj = early ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
   assign a12 = sm3_pkg::rotl(regs_now[0], 5'd12);
   assign ss1 = sm3_pkg::rotl(a12 + regs_now[4] + sm3_pkg::rotl(tj, round_idx[4:0]), 5'd7);
   assign ss2 = ss1 ^ a12;

   always_comb begin
      if (early) begin
         ff = regs_now[0] ^ regs_now[1] ^ regs_now[2];
         gg = regs_now[4] ^ regs_now[5] ^ regs_now[6];
      end else begin
         ff = (regs_now[0] & regs_now[1]) | (regs_now[0] & regs_now[2])
            | (regs_now[1] & regs_now[2]);
         gg = (regs_now[4] & regs_now[5]) | (~regs_now[4] & regs_now[6]);
      end
   end

   assign tt1 = ff + regs_now[3] + ss2 + (taps.w0 ^ taps.w4);
   assign tt2 = gg + regs_now[7] + ss1 + taps.w0;

   always_comb begin
      regs_next[3] = regs_now[2];
      regs_next[2] = sm3_pkg::rotl(regs_now[1], 5'd9);
      regs_next[1] = regs_now[0];
      regs_next[0] = tt1;
      regs_next[7] = regs_now[6];
      regs_next[6] = sm3_pkg::rotl(regs_now[5], 5'd19);
      regs_next[5] = regs_now[4];
      regs_next[4] = sm3_pkg::perm0(tt2);
   end

   // Next expanded word W[j+16] from the sliding window.
   assign w_new = sm3_pkg::perm1(taps.w0 ^ taps.w7 ^ sm3_pkg::rotl(taps.w13, 5'd15))
                ^ sm3_pkg::rotl(taps.w3, 5'd7) ^ taps.w10;

endmodule

`default_nettype wire

>>> rtl/core/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-serial SM3 (256-bit digest) with padding and an iterative round unit.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one message byte per request, with byte_valid to
// mark a real byte and msg_last to end the message. Bytes are taken one per
// cycle while a 64-byte block fills. The request that completes a block
// starts a compression: the rounds through the one round unit, then a fold
// into the chaining value, while req.ready is low. A request with msg_last
// pads the message one byte per cycle (0x80, zeros to offset 56, the 64-bit
// bit length), running one or two more compressions. The digest is then
// held on the rsp channel until it is taken; no request is accepted while
// it waits. After it is taken the engine returns to the initial value with
// a zero count. An empty message is a last request with byte_valid low.
// Synchronous reset puts the engine into the same fresh state, with no
// result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine (
   input  wire logic   clock,
   input  wire logic   reset,
   sm3_req_if.sink     req_chan,
   sm3_rsp_if.source   rsp_chan
);

   sm3_pkg::state_type state_ff, state_in;
   logic [5:0]         round_ff, round_in;
   logic [5:0]         pos_ff, pos_in;
   logic [63:0]        count_ff, count_in;
   logic [63:0]        len_ff, len_in;
   logic               pad_ff, pad_in;
   logic               mark_ff, mark_in;
   logic               lenact_ff, lenact_in;
   logic               done_ff, done_in;
   sm3_pkg::regs_type  chain_ff, chain_in;
   sm3_pkg::regs_type  regs_ff, regs_in;
   sm3_pkg::word_type  window_ff [16];
   sm3_pkg::word_type  window_in [16];

   logic               req_ready;
   logic               rsp_valid;
   logic               accept;
   logic               out_done;
   logic               place;
   logic               run;
   logic               fold;
   logic               len_phase;
   logic               blk_full;
   logic [7:0]         place_byte;
   logic [63:0]        count_inc;
   sm3_pkg::taps_type  taps;
   sm3_pkg::regs_type  regs_next;
   sm3_pkg::word_type  w_new;

   assign accept    = req_chan.valid && req_ready;
   assign out_done  = rsp_valid && rsp_chan.ready;
   assign len_phase = mark_ff && (lenact_ff || pos_ff == sm3_pkg::LEN_POS);
   assign blk_full  = place && (pos_ff == sm3_pkg::LAST_POS);
   assign count_inc = count_ff + {63'd0, req_chan.byte_valid};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sm3_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.byte_valid && pos_ff == sm3_pkg::LAST_POS) begin
                  state_in = sm3_pkg::ST_RUN;
               end else if (req_chan.msg_last) begin
                  state_in = sm3_pkg::ST_PAD;
               end
            end
         end
         sm3_pkg::ST_PAD: begin
            if (pos_ff == sm3_pkg::LAST_POS) begin
               state_in = sm3_pkg::ST_RUN;
            end
         end
         sm3_pkg::ST_RUN: begin
            if (round_ff == sm3_pkg::LAST_ROUND) begin
               state_in = sm3_pkg::ST_FOLD;
            end
         end
         sm3_pkg::ST_FOLD: begin
            if (done_ff) begin
               state_in = sm3_pkg::ST_OUT;
            end else if (pad_ff) begin
               state_in = sm3_pkg::ST_PAD;
            end else begin
               state_in = sm3_pkg::ST_IDLE;
            end
         end
         sm3_pkg::ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = sm3_pkg::ST_IDLE;
            end
         end
         default: state_in = sm3_pkg::ST_IDLE;
      endcase
   end

   // State decode.
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      place      = 1'b0;
      run        = 1'b0;
      fold       = 1'b0;
      place_byte = req_chan.msg_byte;
      case (state_ff)
         sm3_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            place     = req_chan.valid && req_chan.byte_valid;
         end
         sm3_pkg::ST_PAD: begin
            place = 1'b1;
            if (!mark_ff) begin
               place_byte = sm3_pkg::PAD_MARK;
            end else if (len_phase) begin
               place_byte = len_ff[63:56];
            end else begin
               place_byte = 8'h00;
            end
         end
         sm3_pkg::ST_RUN:  run = 1'b1;
         sm3_pkg::ST_FOLD: fold = 1'b1;
         sm3_pkg::ST_OUT:  rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   // Control and counters.
   always_comb begin
      round_in  = round_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      pad_in    = pad_ff;
      mark_in   = mark_ff;
      lenact_in = lenact_ff;
      done_in   = done_ff;
      chain_in  = chain_ff;
      if (run) begin
         round_in = round_ff + 6'd1;
      end
      if (place) begin
         pos_in = pos_ff + 6'd1;
      end
      if (accept) begin
         count_in = count_inc;
         if (req_chan.msg_last) begin
            pad_in = 1'b1;
         end
      end
      if (state_ff == sm3_pkg::ST_PAD) begin
         mark_in = 1'b1;
         if (len_phase) begin
            lenact_in = 1'b1;
            if (pos_ff == sm3_pkg::LAST_POS) begin
               done_in = 1'b1;
            end
         end
      end
      if (fold) begin
         for (int k = 0; k < 8; k++) begin
            chain_in[k] = chain_ff[k] ^ regs_ff[k];
         end
      end
      if (out_done) begin
         pos_in    = 6'd0;
         count_in  = 64'd0;
         pad_in    = 1'b0;
         mark_in   = 1'b0;
         lenact_in = 1'b0;
         done_in   = 1'b0;
         chain_in  = sm3_pkg::SM3_IV;
      end
   end

   // Datapath: length shifter, working registers and message window.
   always_comb begin
      len_in = len_ff;
      if (accept && req_chan.msg_last) begin
         len_in = {count_inc[60:0], 3'b000};
      end else if (state_ff == sm3_pkg::ST_PAD && len_phase) begin
         len_in = {len_ff[55:0], 8'h00};
      end
      regs_in = regs_ff;
      if (blk_full) begin
         regs_in = chain_ff;
      end else if (run) begin
         regs_in = regs_next;
      end
      window_in = window_ff;
      if (place) begin
         // The 64-byte block slides left by one byte; the new byte enters last.
         for (int k = 0; k < 15; k++) begin
            window_in[k] = {window_ff[k][23:0], window_ff[k + 1][31:24]};
         end
         window_in[15] = {window_ff[15][23:0], place_byte};
      end else if (run) begin
         for (int k = 0; k < 15; k++) begin
            window_in[k] = window_ff[k + 1];
         end
         window_in[15] = w_new;
      end
   end

   assign taps.w0  = window_ff[0];
   assign taps.w3  = window_ff[3];
   assign taps.w4  = window_ff[4];
   assign taps.w7  = window_ff[7];
   assign taps.w10 = window_ff[10];
   assign taps.w13 = window_ff[13];

   sm3_round u_round (
      .regs_now  (regs_ff),
      .taps      (taps),
      .round_idx (round_ff),
      .regs_next (regs_next),
      .w_new     (w_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sm3_pkg::ST_IDLE;
         round_ff  <= 6'd0;
         pos_ff    <= 6'd0;
         count_ff  <= 64'd0;
         pad_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         lenact_ff <= 1'b0;
         done_ff   <= 1'b0;
         chain_ff  <= sm3_pkg::SM3_IV;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         pad_ff    <= pad_in;
         mark_ff   <= mark_in;
         lenact_ff <= lenact_in;
         done_ff   <= done_in;
         chain_ff  <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      regs_ff   <= regs_in;
      window_ff <= window_in;
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.digest_word_0 = chain_ff[0];
   assign rsp_chan.digest_word_1 = chain_ff[1];
   assign rsp_chan.digest_word_2 = chain_ff[2];
   assign rsp_chan.digest_word_3 = chain_ff[3];
   assign rsp_chan.digest_word_4 = chain_ff[4];
   assign rsp_chan.digest_word_5 = chain_ff[5];
   assign rsp_chan.digest_word_6 = chain_ff[6];
   assign rsp_chan.digest_word_7 = chain_ff[7];

   // The engine never takes a request while a digest is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while digest pending");

   // The last round is always followed by the fold into the chaining value.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sm3_pkg::ST_RUN && round_ff == sm3_pkg::LAST_ROUND)
      |=> (state_ff == sm3_pkg::ST_FOLD && round_ff == 6'd0))
      else $error("compression did not end after the last round");

   // Padding always ends on a block boundary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff == 6'd0 && done_ff))
      else $error("digest shown with a partial block");

   // A compression starts only on the byte that fills the block.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(run)) |-> $past(blk_full))
      else $error("compression started without a full block");

endmodule

`default_nettype wire

>>> test/sm3_digest_checker.sv
// ----------------------------------------------------------------------------
// SM3 digest checker
// Watches the request and digest channels of the SM3 hash engine. It rebuilds
// each message from the accepted requests, computes its SM3 digest and
// compares every returned digest, word by word, with the oldest one expected.
// ----------------------------------------------------------------------------

module sm3_digest_checker (
   input  logic clock,
   input  logic reset,
   sm3_req_if   req_mon,
   sm3_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] chain_type;

   // Word 0 of the initial chaining value sits at index 0.
   localparam chain_type INIT_CHAIN = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };
   localparam word_type   ROUND_CONST_EARLY = 32'h79cc4519;
   localparam word_type   ROUND_CONST_LATE  = 32'h7a879d8a;
   localparam logic [7:0] PAD_BYTE          = 8'h80;
   localparam logic [5:0] LENGTH_OFFSET     = 6'd56;

   chain_type   chain_state;
   logic [7:0]  block_bytes [64];
   logic [5:0]  fill_pos;
   logic [63:0] msg_length;
   chain_type   digest_queue [$];

   function automatic word_type rol32(input word_type x, input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0) begin
         return x;
      end
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic word_type mix_p0(input word_type x);
      return x ^ rol32(x, 9) ^ rol32(x, 17);
   endfunction

   function automatic word_type mix_p1(input word_type x);
      return x ^ rol32(x, 15) ^ rol32(x, 23);
   endfunction

   // Compresses the 64 buffered bytes into the chaining value.
   function automatic void compress_block();
      word_type w [68];
      word_type a, b, c, d, e, f, g, h;
      word_type a12, ss1, ss2, tt1, tt2, ff, gg, tj;
      int       j;
      for (j = 0; j < 16; j++) begin
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
                 block_bytes[4*j+3]};
      end
      for (j = 16; j < 68; j++) begin
         w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7)
                ^ w[j-6];
      end
      {h, g, f, e, d, c, b, a} = chain_state;
      for (j = 0; j < 64; j++) begin
         tj  = (j < 16) ? ROUND_CONST_EARLY : ROUND_CONST_LATE;
         a12 = rol32(a, 12);
         ss1 = rol32(a12 + e + rol32(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c;
         c = rol32(b, 9);
         b = a;
         a = tt1;
         h = g;
         g = rol32(f, 19);
         f = e;
         e = mix_p0(tt2);
      end
      chain_state = chain_state ^ {h, g, f, e, d, c, b, a};
   endfunction

   function automatic void put_byte(input logic [7:0] v);
      block_bytes[fill_pos] = v;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) begin
         compress_block();
      end
   endfunction

   function automatic void restart_message();
      chain_state = INIT_CHAIN;
      fill_pos    = '0;
      msg_length  = '0;
   endfunction

   // Pads the message, runs the remaining compressions and returns the digest.
   function automatic chain_type finish_message();
      logic [63:0] bit_len;
      chain_type   result;
      int          k;
      bit_len = msg_length << 3;
      put_byte(PAD_BYTE);
      while (fill_pos != LENGTH_OFFSET) begin
         put_byte(8'h00);
      end
      for (k = 0; k < 8; k++) begin
         put_byte(bit_len[63-8*k -: 8]);
      end
      result = chain_state;
      restart_message();
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: digest mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_digest();
      chain_type got;
      chain_type want;
      int        k;
      got = {rsp_mon.digest_word_7, rsp_mon.digest_word_6, rsp_mon.digest_word_5,
             rsp_mon.digest_word_4, rsp_mon.digest_word_3, rsp_mon.digest_word_2,
             rsp_mon.digest_word_1, rsp_mon.digest_word_0};
      if (digest_queue.size() == 0) begin
         report_mismatch($sformatf("digest %h with no message outstanding", got));
      end else begin
         want = digest_queue.pop_front();
         for (k = 0; k < 8; k++) begin
            if (got[k] !== want[k]) begin
               report_mismatch($sformatf("word %0d is %h, expected %h",
                                         k, got[k], want[k]));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.byte_valid) begin
               put_byte(req_mon.msg_byte);
               msg_length = msg_length + 64'd1;
            end
            if (req_mon.msg_last) begin
               digest_queue.push_back(finish_message());
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_digest();
         end
      end
      pending = digest_queue.size();
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Feeds directed and random byte-serial messages with random gaps on both
// channels, a long digest hold-off and a stretch with no gaps. The checker
// beside the engine predicts and compares every digest.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 200;
   localparam int ITEM_TARGET   = 700;
   localparam int DIGEST_TARGET = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   stall_pct;
   bit   hold_rsp;
   int   items_sent;
   int   messages_sent;

   // Lengths around the padding and block boundaries.
   int corner_lengths [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sm3_req_if req_chan ();
   sm3_rsp_if rsp_chan ();

   sm3_hash_engine u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sm3_digest_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_top NOT OK");
      $finish;
   end

   // Digest receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one request and returns at the clock edge that accepts it.
   task automatic push_request(input logic [7:0] b, input logic v, input logic l);
      while ($urandom_range(99) < stall_pct) begin
         @(negedge clock);
         req_chan.valid      <= 1'b0;
         req_chan.msg_byte   <= 8'($urandom);
         req_chan.byte_valid <= 1'($urandom);
         req_chan.msg_last   <= 1'($urandom);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.msg_byte   <= b;
      req_chan.byte_valid <= v;
      req_chan.msg_last   <= l;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         return corner_lengths[$urandom_range(11)];
      end else if (r < 20) begin
         return $urandom_range(200, 129);
      end
      return $urandom_range(30, 0);
   endfunction

   // One well-formed message with random content; the end is flagged either
   // on the final byte or on a separate request that carries no byte.
   task automatic send_message(input int len, input int noise_pct);
      int i;
      bit tail;
      tail = (len == 0) ? 1'b1 : 1'($urandom);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            push_request(8'($urandom), 1'b0, 1'b0);
            items_sent++;
         end
         push_request(8'($urandom), 1'b1, !tail && (i == len - 1));
         items_sent++;
      end
      if (tail) begin
         push_request(8'($urandom), 1'b0, 1'b1);
         items_sent++;
      end
      messages_sent++;
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.msg_byte   = 8'h00;
      req_chan.byte_valid = 1'b0;
      req_chan.msg_last   = 1'b0;
      reset               = 1'b1;
      stall_pct           = 34;
      hold_rsp            = 1'b0;
      items_sent          = 0;
      messages_sent       = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // A request with neither a byte nor an end must change nothing.
      push_request(8'hff, 1'b0, 1'b0);
      // Empty message on a fresh engine.
      push_request(8'h00, 1'b0, 1'b1);
      // "abc" with an ignored request in the middle.
      push_request(8'h61, 1'b1, 1'b0);
      push_request(8'h00, 1'b0, 1'b0);
      push_request(8'h62, 1'b1, 1'b0);
      push_request(8'h63, 1'b1, 1'b1);
      // Single bytes at both extremes.
      push_request(8'hff, 1'b1, 1'b1);
      push_request(8'h00, 1'b1, 1'b0);
      push_request(8'hff, 1'b0, 1'b1);
      // Empty message right after a digest; the byte field must be ignored.
      push_request(8'hff, 1'b0, 1'b1);
      messages_sent = 0;

      while (items_sent < ITEM_TARGET || messages_sent < DIGEST_TARGET) begin
         // Stall the digest side long enough for the engine to back up.
         if (messages_sent == 6) begin
            hold_rsp = 1'b1;
         end
         stall_pct = (messages_sent >= 12 && messages_sent < 18) ? 0 : 34;
         send_message(pick_length(), ($urandom_range(9) == 0) ? 30 : 5);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/sm3_pkg.sv
rtl/core/sm3_if.sv
rtl/core/sm3_round.sv
rtl/core/sm3_hash_engine.sv
test/sm3_digest_checker.sv
test/tb_top.sv
